FILE: rtl/core/ir_pulse_interval_decoder_core_assert.svh
// Assertion macros for the infrared pulse interval decoder.
`ifndef IR_PULSE_INTERVAL_DECODER_CORE_ASSERT_SVH
`define IR_PULSE_INTERVAL_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked property with an active-low reset that disables the check.
`define IRPID_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is checked during reset as well.
`define IRPID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IRPID_ASSERT(lbl, clk, rst_n, prop, msg)
`define IRPID_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/core/irpid_pkg.sv
// Shared types and constants of the infrared pulse interval decoder.
package irpid_pkg;

  localparam int unsigned FrameBitsDef = 32;
  localparam int unsigned TimerBitsDef = 16;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEADER_LOW  = 3'd0,
    REG_LEADER_HIGH = 3'd1,
    REG_SPACE_LOW   = 3'd2,
    REG_SPACE_HIGH  = 3'd3,
    REG_ONE_LOW     = 3'd4,
    REG_ONE_HIGH    = 3'd5
  } reg_idx_e;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_READ = 1'b1
  } op_e;

  localparam logic [CfgDataW-1:0] LeaderLowRst  = 16'd8500;
  localparam logic [CfgDataW-1:0] LeaderHighRst = 16'd9500;
  localparam logic [CfgDataW-1:0] SpaceLowRst   = 16'd4000;
  localparam logic [CfgDataW-1:0] SpaceHighRst  = 16'd5000;
  localparam logic [CfgDataW-1:0] OneLowRst     = 16'd1500;
  localparam logic [CfgDataW-1:0] OneHighRst    = 16'd1800;

  typedef struct packed {
    logic [CfgDataW-1:0] leader_low;
    logic [CfgDataW-1:0] leader_high;
    logic [CfgDataW-1:0] space_low;
    logic [CfgDataW-1:0] space_high;
    logic [CfgDataW-1:0] one_low;
    logic [CfgDataW-1:0] one_high;
  } cfg_t;

  // Status that travels with each result.
  typedef struct packed {
    logic ready_res;
    logic frame_done;
  } stat_t;

endpackage

FILE: rtl/core/irpid_if.sv
// Valid/ready channel interfaces for edge items and decoder results.
interface irpid_edge_if #(
  parameter int unsigned TIMER_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [TIMER_BITS-1:0] edge_time;

  modport source (output valid, output opcode, output edge_time, input ready);
  modport sink   (input valid, input opcode, input edge_time, output ready);
endinterface

interface irpid_result_if #(
  parameter int unsigned FRAME_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [FRAME_BITS-1:0] received_code;
  logic                  ready_res;
  logic                  frame_done;

  modport source (output valid, output received_code, output ready_res,
                  output frame_done, input ready);
  modport sink   (input valid, input received_code, input ready_res,
                  input frame_done, output ready);
endinterface

FILE: rtl/core/irpid_regs.sv
// Interval window threshold registers with a plain write port.
module irpid_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [irpid_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [irpid_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output irpid_pkg::cfg_t                 cfg_o
);
  import irpid_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_LEADER_LOW:  cfg_d.leader_low  = cfg_wdata_i;
        REG_LEADER_HIGH: cfg_d.leader_high = cfg_wdata_i;
        REG_SPACE_LOW:   cfg_d.space_low   = cfg_wdata_i;
        REG_SPACE_HIGH:  cfg_d.space_high  = cfg_wdata_i;
        REG_ONE_LOW:     cfg_d.one_low     = cfg_wdata_i;
        REG_ONE_HIGH:    cfg_d.one_high    = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_low  <= LeaderLowRst;
      cfg_q.leader_high <= LeaderHighRst;
      cfg_q.space_low   <= SpaceLowRst;
      cfg_q.space_high  <= SpaceHighRst;
      cfg_q.one_low     <= OneLowRst;
      cfg_q.one_high    <= OneHighRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/irpid_engine.sv
// Decoder state and the update logic for one registered item.
module irpid_engine #(
  parameter int unsigned FRAME_BITS = irpid_pkg::FrameBitsDef,
  parameter int unsigned TIMER_BITS = irpid_pkg::TimerBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  opcode_i,
  input  logic [TIMER_BITS-1:0] edge_time_i,
  input  irpid_pkg::cfg_t       cfg_i,
  output logic [FRAME_BITS-1:0] code_o,
  output irpid_pkg::stat_t      stat_o
);
  import irpid_pkg::*;

  localparam int unsigned IdxW = $clog2(FRAME_BITS + 1);
  localparam int unsigned BitW = $clog2(FRAME_BITS);
  localparam int unsigned CmpW = (TIMER_BITS > CfgDataW) ? TIMER_BITS : CfgDataW;
  localparam logic [IdxW-1:0] FrameEnd = IdxW'(FRAME_BITS);

  logic [TIMER_BITS-1:0] prev_q, prev_d;
  logic [FRAME_BITS-1:0] code_q, code_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic                  rdy_q, rdy_d;

  logic [TIMER_BITS-1:0] delta;
  logic [CmpW-1:0]       delta_x;
  logic                  hit_hdr, hit_one, done;
  logic [FRAME_BITS-1:0] code_mid;
  logic [IdxW-1:0]       idx_mid;

  function automatic logic in_win(logic [CmpW-1:0] d, logic [CfgDataW-1:0] lo,
                                  logic [CfgDataW-1:0] hi);
    return (d > CmpW'(lo)) && (d < CmpW'(hi));
  endfunction

  assign delta   = edge_time_i - prev_q;
  assign delta_x = CmpW'(delta);
  assign hit_hdr = in_win(delta_x, cfg_i.leader_low, cfg_i.leader_high) ||
                   in_win(delta_x, cfg_i.space_low, cfg_i.space_high);
  assign hit_one = in_win(delta_x, cfg_i.one_low, cfg_i.one_high);

  always_comb begin
    code_mid = code_q;
    idx_mid  = idx_q;
    if (hit_hdr) begin
      code_mid = '0;
      idx_mid  = '0;
    end else if (hit_one && (idx_q < FrameEnd)) begin
      code_mid[idx_q[BitW-1:0]] = 1'b1;
    end
  end

  assign done = (opcode_i == OP_EDGE) && (idx_mid >= FrameEnd);

  always_comb begin
    prev_d = prev_q;
    code_d = code_q;
    idx_d  = idx_q;
    rdy_d  = rdy_q;
    if (opcode_i == OP_EDGE) begin
      prev_d = edge_time_i;
      code_d = code_mid;
      if (done) begin
        rdy_d = 1'b1;
        idx_d = '0;
      end else begin
        idx_d = idx_mid + IdxW'(1);
      end
    end else begin
      rdy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      code_q <= '0;
      idx_q  <= '0;
      rdy_q  <= 1'b0;
    end else if (step_i) begin
      prev_q <= prev_d;
      code_q <= code_d;
      idx_q  <= idx_d;
      rdy_q  <= rdy_d;
    end
  end

  // Values after this item, taken by the result register.
  assign code_o           = code_d;
  assign stat_o.ready_res  = rdy_d;
  assign stat_o.frame_done = done;

endmodule

FILE: rtl/core/ir_pulse_interval_decoder_core.sv
// Top level of the infrared pulse interval decoder: item stages and handshakes.
//
//   channel    dir   handshake      payload
//   in_ch      in    valid/ready    opcode, edge_time
//   out_ch     out   valid/ready    received_code, ready_res, frame_done
//   cfg        in    cfg_we_i       cfg_index_i, cfg_wdata_i
//
// One item is taken per cycle unless the result stalls.
// The input register feeds one update step and the result register holds the answer.
// Reset loads the default windows and clears the code, bit index and ready flag.
// A stalled result blocks the update step, and the input register then fills and stalls.
`include "ir_pulse_interval_decoder_core_assert.svh"

module ir_pulse_interval_decoder_core #(
  parameter int unsigned FRAME_BITS = irpid_pkg::FrameBitsDef,
  parameter int unsigned TIMER_BITS = irpid_pkg::TimerBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  irpid_edge_if.sink                      in_ch,
  irpid_result_if.source                  out_ch,
  input  logic                            cfg_we_i,
  input  logic [irpid_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [irpid_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import irpid_pkg::*;

  cfg_t                  cfg;
  logic                  in_valid_q, in_valid_d;
  logic                  in_op_q;
  logic [TIMER_BITS-1:0] in_time_q;
  logic                  in_take, step;
  logic [FRAME_BITS-1:0] code_next;
  stat_t                 stat_next;
  logic                  out_valid_q, out_valid_d;
  logic [FRAME_BITS-1:0] out_code_q;
  stat_t                 out_stat_q;
  logic                  out_done, out_rdy, out_flags, read_step, in_hold;

  irpid_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  irpid_engine #(
    .FRAME_BITS (FRAME_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .opcode_i    (in_op_q),
    .edge_time_i (in_time_q),
    .cfg_i       (cfg),
    .code_o      (code_next),
    .stat_o      (stat_next)
  );

  assign step         = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready  = !in_valid_q || step;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q   <= in_ch.opcode;
      in_time_q <= in_ch.edge_time;
    end
    if (step) begin
      out_code_q <= code_next;
      out_stat_q <= stat_next;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.received_code = out_code_q;
  assign out_ch.ready_res     = out_stat_q.ready_res;
  assign out_ch.frame_done    = out_stat_q.frame_done;

  assign out_done  = out_valid_q && out_stat_q.frame_done;
  assign out_rdy   = out_stat_q.ready_res;
  assign out_flags = out_stat_q.ready_res || out_stat_q.frame_done;
  assign read_step = step && (in_op_q == OP_READ);
  assign in_hold   = in_valid_q && !step;

  `IRPID_ASSERT(a_done_sets_ready, clk_i, rst_ni, out_done |-> out_rdy, "frame end without ready")
  `IRPID_ASSERT(a_read_clears, clk_i, rst_ni, read_step |=> !out_flags, "read left a flag set")
  `IRPID_ASSERT(a_in_hold, clk_i, rst_ni, in_hold |=> in_valid_q, "held item dropped")

endmodule
